// File: src/jsu_pkg.sv
// Package for the JSON string unescaper: result status codes, decoder modes,
// character constants, the result bundle type and the hex digit helper.
// No dependencies.
`default_nettype none

package jsu_pkg;

  // Result status codes.
  localparam logic [1:0] ST_DATA   = 2'd0;
  localparam logic [1:0] ST_CLOSE  = 2'd1;
  localparam logic [1:0] ST_BADESC = 2'd2;
  localparam logic [1:0] ST_END    = 2'd3;

  // Decoder modes.
  localparam logic [2:0] MODE_NORMAL = 3'd0;
  localparam logic [2:0] MODE_ESCAPE = 3'd1;
  localparam logic [2:0] MODE_HEX0   = 3'd2;
  localparam logic [2:0] MODE_HEX1   = 3'd3;
  localparam logic [2:0] MODE_HEX2   = 3'd4;
  localparam logic [2:0] MODE_HEX3   = 3'd5;

  // Characters with a meaning of their own.
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_SLASH  = 8'h2f;
  localparam logic [7:0] CH_BSLASH = 8'h5c;
  localparam logic [7:0] CH_B      = 8'h62;
  localparam logic [7:0] CH_F      = 8'h66;
  localparam logic [7:0] CH_N      = 8'h6e;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_U      = 8'h75;

  localparam logic [15:0] REPLACEMENT_CHAR = 16'hfffd;
  localparam logic [15:0] OUT_LEN_MAX      = 16'hffff;

  // Up to three results caused by one input byte.
  typedef struct packed {
    logic [1:0]       cnt;
    logic [2:0][7:0]  bytes;
    logic [1:0]       status;
    logic [15:0]      length;
  } bundle_t;

  // Returns {valid, value} for one hex digit, either case.
  function automatic logic [4:0] hex_value(logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, 4'(c - 8'h30)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r = {1'b1, 4'(c - 8'h57)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r = {1'b1, 4'(c - 8'h37)};
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// File: src/jsu_if.sv
// Valid/ready channel interfaces for the JSON string unescaper.
// Depends on nothing but the sizes of the payload fields.
`default_nettype none

interface jsu_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

interface jsu_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  out_byte;
  logic [1:0]  status;
  logic [15:0] out_length;
  logic        last;

  modport source (output valid, output out_byte, output status, output out_length,
                  output last, input ready);
  modport sink   (input valid, input out_byte, input status, input out_length,
                  input last, output ready);
endinterface

`default_nettype wire

// File: src/jsu_decode.sv
// Input register, decoder state and the combinational decode of one byte
// into a bundle of up to three results. Depends on jsu_pkg.
`default_nettype none

module jsu_decode #(
  parameter int LENGTH_BITS = 16
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  input  wire logic [7:0]       in_byte_i,
  output logic                  in_ready_o,
  input  wire logic             adv_i,
  output logic                  load_o,
  output jsu_pkg::bundle_t      bundle_o
);

  logic                   in_vld_q, in_vld_d;
  logic [7:0]             in_byte_q;
  logic [2:0]             mode_q, mode_d;
  logic [11:0]            acc_q, acc_d;
  logic [LENGTH_BITS-1:0] count_q, count_d;
  logic [LENGTH_BITS:0]   count_sum;
  logic [1:0]             add_n;
  logic [15:0]            len_sat;
  logic [15:0]            cp;
  logic [4:0]             hx;
  logic [8:0]             esc;
  logic                   fire;
  jsu_pkg::bundle_t       b;

  // Single-byte escapes; returns {valid, byte}.
  function automatic logic [8:0] esc_map(logic [7:0] c);
    logic [8:0] r;
    r = 9'd0;
    unique case (c)
      jsu_pkg::CH_QUOTE:  r = {1'b1, jsu_pkg::CH_QUOTE};
      jsu_pkg::CH_BSLASH: r = {1'b1, jsu_pkg::CH_BSLASH};
      jsu_pkg::CH_SLASH:  r = {1'b1, jsu_pkg::CH_SLASH};
      jsu_pkg::CH_B:      r = {1'b1, 8'h08};
      jsu_pkg::CH_F:      r = {1'b1, 8'h0c};
      jsu_pkg::CH_N:      r = {1'b1, 8'h0a};
      jsu_pkg::CH_R:      r = {1'b1, 8'h0d};
      jsu_pkg::CH_T:      r = {1'b1, 8'h09};
      default:            r = 9'd0;
    endcase
    return r;
  endfunction

  generate
    if (LENGTH_BITS > 16) begin : g_len_sat
      assign len_sat = (|count_q[LENGTH_BITS-1:16]) ? jsu_pkg::OUT_LEN_MAX
                                                    : count_q[15:0];
    end else begin : g_len_ext
      assign len_sat = 16'(count_q);
    end
  endgenerate

  assign in_ready_o = !in_vld_q || adv_i;
  assign fire       = in_vld_q && adv_i;
  assign in_vld_d   = in_ready_o ? in_valid_i : in_vld_q;

  assign hx  = jsu_pkg::hex_value(in_byte_q);
  assign esc = esc_map(in_byte_q);

  always_comb begin
    cp = {acc_q, hx[3:0]};
    if (cp == 16'd0) begin
      cp = jsu_pkg::REPLACEMENT_CHAR;
    end
  end

  always_comb begin
    b        = '0;
    b.status = jsu_pkg::ST_DATA;
    mode_d   = mode_q;
    acc_d    = acc_q;
    add_n    = 2'd0;
    unique case (mode_q)
      jsu_pkg::MODE_ESCAPE: begin
        mode_d = jsu_pkg::MODE_NORMAL;
        if (in_byte_q == jsu_pkg::CH_NUL) begin
          b.cnt    = 2'd1;
          b.status = jsu_pkg::ST_END;
        end else if (esc[8]) begin
          b.cnt      = 2'd1;
          b.bytes[0] = esc[7:0];
          add_n      = 2'd1;
        end else if (in_byte_q == jsu_pkg::CH_U) begin
          mode_d = jsu_pkg::MODE_HEX0;
          acc_d  = 12'd0;
        end else begin
          b.cnt    = 2'd1;
          b.status = jsu_pkg::ST_BADESC;
        end
      end
      jsu_pkg::MODE_HEX0, jsu_pkg::MODE_HEX1, jsu_pkg::MODE_HEX2: begin
        if (hx[4]) begin
          acc_d  = {acc_q[7:0], hx[3:0]};
          mode_d = mode_q + 3'd1;
        end else begin
          b.cnt    = 2'd1;
          b.status = jsu_pkg::ST_BADESC;
          mode_d   = jsu_pkg::MODE_NORMAL;
        end
      end
      jsu_pkg::MODE_HEX3: begin
        mode_d = jsu_pkg::MODE_NORMAL;
        acc_d  = 12'd0;
        if (!hx[4]) begin
          b.cnt    = 2'd1;
          b.status = jsu_pkg::ST_BADESC;
        end else if (cp < 16'h0080) begin
          b.cnt      = 2'd1;
          b.bytes[0] = cp[7:0];
          add_n      = 2'd1;
        end else if (cp < 16'h0800) begin
          b.cnt      = 2'd2;
          b.bytes[0] = {3'b110, cp[10:6]};
          b.bytes[1] = {2'b10, cp[5:0]};
          add_n      = 2'd2;
        end else begin
          b.cnt      = 2'd3;
          b.bytes[0] = {4'b1110, cp[15:12]};
          b.bytes[1] = {2'b10, cp[11:6]};
          b.bytes[2] = {2'b10, cp[5:0]};
          add_n      = 2'd3;
        end
      end
      default: begin
        // Normal mode; the unused mode codes behave the same.
        mode_d = jsu_pkg::MODE_NORMAL;
        if (in_byte_q == jsu_pkg::CH_NUL) begin
          b.cnt    = 2'd1;
          b.status = jsu_pkg::ST_END;
        end else if (in_byte_q == jsu_pkg::CH_QUOTE) begin
          b.cnt    = 2'd1;
          b.status = jsu_pkg::ST_CLOSE;
          b.length = len_sat;
          acc_d    = 12'd0;
        end else if (in_byte_q == jsu_pkg::CH_BSLASH) begin
          mode_d = jsu_pkg::MODE_ESCAPE;
        end else begin
          b.cnt      = 2'd1;
          b.bytes[0] = in_byte_q;
          add_n      = 2'd1;
        end
      end
    endcase

    // Errors, the end and the close reset the count and the accumulator.
    if (b.cnt != 2'd0 && b.status != jsu_pkg::ST_DATA) begin
      acc_d = 12'd0;
    end
  end

  assign count_sum = {1'b0, count_q} + (LENGTH_BITS+1)'(add_n);

  always_comb begin
    if (b.cnt != 2'd0 && b.status != jsu_pkg::ST_DATA) begin
      count_d = '0;
    end else if (count_sum[LENGTH_BITS]) begin
      count_d = '1;
    end else begin
      count_d = count_sum[LENGTH_BITS-1:0];
    end
  end

  assign load_o   = fire && (b.cnt != 2'd0);
  assign bundle_o = b;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
      mode_q   <= jsu_pkg::MODE_NORMAL;
      acc_q    <= 12'd0;
      count_q  <= '0;
    end else begin
      in_vld_q <= in_vld_d;
      if (fire) begin
        mode_q  <= mode_d;
        acc_q   <= acc_d;
        count_q <= count_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_byte_q <= in_byte_i;
    end
  end

endmodule

`default_nettype wire

// File: src/jsu_emit.sv
// Result register: holds one bundle of up to three results and hands them
// out one per cycle on the output channel while it is ready. Depends on jsu_pkg.
`default_nettype none

module jsu_emit (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             load_i,
  input  wire jsu_pkg::bundle_t bundle_i,
  output logic                  adv_o,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output logic [7:0]            out_byte_o,
  output logic [1:0]            status_o,
  output logic [15:0]           out_length_o,
  output logic                  last_o
);

  logic [1:0]      rem_q, rem_d;
  logic [2:0][7:0] bytes_q;
  logic [1:0]      status_q;
  logic [15:0]     length_q;
  logic            pop;

  assign out_valid_o  = (rem_q != 2'd0);
  assign pop          = out_valid_o && out_ready_i;
  // The register is free when empty or once its final result leaves in this cycle.
  assign adv_o        = (rem_q == 2'd0) || (rem_q == 2'd1 && out_ready_i);
  assign out_byte_o   = bytes_q[0];
  assign status_o     = status_q;
  assign out_length_o = length_q;
  assign last_o       = (rem_q == 2'd1);

  always_comb begin
    rem_d = rem_q;
    if (load_i) begin
      rem_d = bundle_i.cnt;
    end else if (pop) begin
      rem_d = rem_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q <= 2'd0;
    end else begin
      rem_q <= rem_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      bytes_q  <= bundle_i.bytes;
      status_q <= bundle_i.status;
      length_q <= bundle_i.length;
    end else if (pop) begin
      bytes_q[0] <= bytes_q[1];
      bytes_q[1] <= bytes_q[2];
    end
  end

endmodule

`default_nettype wire

// File: src/json_string_unescape_utf8.sv
// JSON string body unescaper with UTF-8 output; uses jsu_pkg, jsu_if,
// jsu_decode and jsu_emit.
// The input register holds a byte while it is decoded; the result register
// holds its results. Throughput: one byte per cycle while the output is
// ready; a \u escape giving two or three UTF-8 bytes stalls the input meanwhile.
// Reset clears the decoder to normal mode with zero count and empties both stages.
`default_nettype none

module json_string_unescape_utf8 #(
  parameter int LENGTH_BITS = 16
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  jsu_in_if.sink     in_i,
  jsu_out_if.source  out_o
);

  logic             adv;
  logic             load;
  jsu_pkg::bundle_t bundle;

  jsu_decode #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_decode (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_byte_i  (in_i.in_byte),
    .in_ready_o (in_i.ready),
    .adv_i      (adv),
    .load_o     (load),
    .bundle_o   (bundle)
  );

  jsu_emit u_emit (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .load_i       (load),
    .bundle_i     (bundle),
    .adv_o        (adv),
    .out_valid_o  (out_o.valid),
    .out_ready_i  (out_o.ready),
    .out_byte_o   (out_o.out_byte),
    .status_o     (out_o.status),
    .out_length_o (out_o.out_length),
    .last_o       (out_o.last)
  );

  // Close and error results always stand alone.
  a_ctrl_single : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.status != jsu_pkg::ST_DATA |-> out_o.last)
    else $error("control result not marked last");

  // Only a close carries a length.
  a_len_close : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.status != jsu_pkg::ST_CLOSE |-> out_o.out_length == 16'd0)
    else $error("length outside a close result");

  // A multi-byte sequence continues with another data byte.
  a_seq_cont : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.ready && !out_o.last
    |=> out_o.valid && out_o.status == jsu_pkg::ST_DATA)
    else $error("UTF-8 sequence broken");

endmodule

`default_nettype wire
